// File: rtl/ckt_pkg.sv
// ----------------------------------------------------------------------------
// ckt_pkg: shared types and program store for the compacting keyed table
// Table sizes, field widths, status codes and the sequencer program that
// drives the table datapath.
// ----------------------------------------------------------------------------
package ckt_pkg;

	// Table geometry
	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// Field widths
	localparam int REQ_W   = 2;
	localparam int CODE_W  = 32;
	localparam int VALUE_W = 24;
	localparam int STAT_W  = 3;
	localparam int ECNT_W  = 7;
	localparam int TOTAL_W = 30;
	localparam int ENTRY_W = CODE_W + VALUE_W;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_ENTRY     = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Branch conditions
	typedef enum logic [2:0] {
		COND_NONE     = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_DISPATCH = 3'd2,
		COND_FULL     = 3'd3,
		COND_IDX_END  = 3'd4,
		COND_LAST     = 3'd5,
		COND_MATCH    = 3'd6,
		COND_EMPTY    = 3'd7
	} cond_t;

	typedef enum logic [1:0] {
		IDX_HOLD  = 2'd0,
		IDX_CLEAR = 2'd1,
		IDX_INC   = 2'd2
	} idx_op_t;

	typedef enum logic [1:0] {
		WR_NONE   = 2'd0,
		WR_APPEND = 2'd1,
		WR_SHIFT  = 2'd2
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	typedef enum logic [1:0] {
		TOT_HOLD = 2'd0,
		TOT_ADD  = 2'd1,
		TOT_SUB  = 2'd2
	} tot_op_t;

	// Program steps
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_FETCH      = 5'd0;
	localparam logic [STEP_W-1:0] STEP_APP_CHK    = 5'd1;
	localparam logic [STEP_W-1:0] STEP_APP_WR     = 5'd2;
	localparam logic [STEP_W-1:0] STEP_DEL_CHK    = 5'd3;
	localparam logic [STEP_W-1:0] STEP_DEL_CMP    = 5'd4;
	localparam logic [STEP_W-1:0] STEP_DEL_NXT    = 5'd5;
	localparam logic [STEP_W-1:0] STEP_DEL_HIT    = 5'd6;
	localparam logic [STEP_W-1:0] STEP_SH_CHK     = 5'd7;
	localparam logic [STEP_W-1:0] STEP_SH_WR      = 5'd8;
	localparam logic [STEP_W-1:0] STEP_SH_END     = 5'd9;
	localparam logic [STEP_W-1:0] STEP_EMIT_DONE  = 5'd10;
	localparam logic [STEP_W-1:0] STEP_EMIT_FULL  = 5'd11;
	localparam logic [STEP_W-1:0] STEP_EMIT_NF    = 5'd12;
	localparam logic [STEP_W-1:0] STEP_LIST_CHK   = 5'd13;
	localparam logic [STEP_W-1:0] STEP_LIST_RD    = 5'd14;
	localparam logic [STEP_W-1:0] STEP_LIST_EMIT  = 5'd15;
	localparam logic [STEP_W-1:0] STEP_LIST_NXT   = 5'd16;
	localparam logic [STEP_W-1:0] STEP_EMIT_EMPTY = 5'd17;

	// One control word per program step
	typedef struct packed {
		logic              accept;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		idx_op_t           idx_op;
		logic              rd_next;
		wr_op_t            wr_op;
		cnt_op_t           cnt_op;
		tot_op_t           tot_op;
		logic              emit;
		status_t           status;
	} uword_t;

	// Entry point of each request type
	function automatic logic [STEP_W-1:0] dispatch(input logic [REQ_W-1:0] req);
		logic [STEP_W-1:0] s;
		unique case (req)
			REQ_APPEND: s = STEP_APP_CHK;
			REQ_DELETE: s = STEP_DEL_CHK;
			REQ_LIST:   s = STEP_LIST_CHK;
			default:    s = STEP_EMIT_DONE;
		endcase
		return s;
	endfunction

	// Program store
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '0;
		unique case (step)
			STEP_FETCH: begin
				w.accept = 1'b1;
				w.cond   = COND_DISPATCH;
				w.idx_op = IDX_CLEAR;
			end
			STEP_APP_CHK: begin
				w.cond   = COND_FULL;
				w.target = STEP_EMIT_FULL;
			end
			STEP_APP_WR: begin
				w.wr_op  = WR_APPEND;
				w.cnt_op = CNT_INC;
				w.tot_op = TOT_ADD;
				w.cond   = COND_ALWAYS;
				w.target = STEP_EMIT_DONE;
			end
			STEP_DEL_CHK: begin
				w.cond   = COND_IDX_END;
				w.target = STEP_EMIT_NF;
			end
			STEP_DEL_CMP: begin
				w.cond   = COND_MATCH;
				w.target = STEP_DEL_HIT;
			end
			STEP_DEL_NXT: begin
				w.idx_op = IDX_INC;
				w.cond   = COND_ALWAYS;
				w.target = STEP_DEL_CHK;
			end
			STEP_DEL_HIT: begin
				w.tot_op = TOT_SUB;
			end
			STEP_SH_CHK: begin
				w.rd_next = 1'b1;
				w.cond    = COND_LAST;
				w.target  = STEP_SH_END;
			end
			STEP_SH_WR: begin
				w.wr_op  = WR_SHIFT;
				w.idx_op = IDX_INC;
				w.cond   = COND_ALWAYS;
				w.target = STEP_SH_CHK;
			end
			STEP_SH_END: begin
				w.cnt_op = CNT_DEC;
			end
			STEP_EMIT_DONE: begin
				w.emit   = 1'b1;
				w.status = ST_DONE;
				w.cond   = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
			STEP_EMIT_FULL: begin
				w.emit   = 1'b1;
				w.status = ST_FULL;
				w.cond   = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
			STEP_EMIT_NF: begin
				w.emit   = 1'b1;
				w.status = ST_NOT_FOUND;
				w.cond   = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
			STEP_LIST_CHK: begin
				w.cond   = COND_EMPTY;
				w.target = STEP_EMIT_EMPTY;
			end
			STEP_LIST_RD: begin
				w.cond = COND_NONE;
			end
			STEP_LIST_EMIT: begin
				w.emit   = 1'b1;
				w.status = ST_ENTRY;
				w.cond   = COND_LAST;
				w.target = STEP_FETCH;
			end
			STEP_LIST_NXT: begin
				w.idx_op = IDX_INC;
				w.cond   = COND_ALWAYS;
				w.target = STEP_LIST_RD;
			end
			STEP_EMIT_EMPTY: begin
				w.emit   = 1'b1;
				w.status = ST_EMPTY;
				w.cond   = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/ckt_ram.sv
// ----------------------------------------------------------------------------
// ckt_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ckt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/compacting_keyed_table.sv
// ----------------------------------------------------------------------------
// compacting_keyed_table: ordered table of (code, value) entries
// Append, delete-by-code with compaction, and list, with a held count and
// a running total of the values.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer sits at its fetch step; every
// request then runs to completion before the next is taken. Append checks
// for a full table and then writes at the end; delete compares entries from
// the front until a match, then moves each later entry down one place, and a
// miss scans every held entry; list reads and emits each entry in turn, or
// reports an empty table; an unknown request only reports done. The program
// steps through the entry RAM, with one write port and a registered read
// port, one entry at a time, and a stalled result side holds the step that
// emits a result.
// The result register lets a finished result wait while the next step runs.
// ----------------------------------------------------------------------------
module compacting_keyed_table
	import ckt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [CODE_W-1:0]  req_code,
	input  logic [VALUE_W-1:0] item_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [ECNT_W-1:0]  entry_count,
	output logic [TOTAL_W-1:0] value_total,
	output logic [CODE_W-1:0]  entry_code,
	output logic [VALUE_W-1:0] entry_value,
	output logic               last
);

	// Sequencer and datapath registers
	logic [STEP_W-1:0]  pc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic [TOTAL_W-1:0] total_q;
	logic [CODE_W-1:0]  req_code_q;
	logic [VALUE_W-1:0] req_value_q;

	// Result register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [ECNT_W-1:0]  out_count_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [CODE_W-1:0]  out_code_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_last_q;

	uword_t             uw;
	logic               in_fire;
	logic               out_free;
	logic               hold;
	logic               go;
	logic               taken;
	logic               idx_last;
	logic               emit_load;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [IDX_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [CODE_W-1:0]  rd_code;
	logic [VALUE_W-1:0] rd_value;

	// Decode the current step
	assign uw       = ucode(pc_q);
	assign in_stall = !uw.accept;
	assign in_fire  = in_valid && uw.accept;
	assign out_free = !out_valid_q || !out_stall;
	assign hold     = (uw.accept && !in_valid) || (uw.emit && !out_free);
	assign go       = !hold;
	assign idx_last = (idx_q + CNT_W'(1)) == cnt_q;
	assign emit_load = go && uw.emit;

	assign rd_code  = rd_data[ENTRY_W-1:VALUE_W];
	assign rd_value = rd_data[VALUE_W-1:0];

	// Evaluate the branch condition
	always_comb begin
		unique case (uw.cond)
			COND_NONE:     taken = 1'b0;
			COND_ALWAYS:   taken = 1'b1;
			COND_DISPATCH: taken = 1'b1;
			COND_FULL:     taken = cnt_q == CNT_W'(DEPTH);
			COND_IDX_END:  taken = idx_q == cnt_q;
			COND_LAST:     taken = idx_last;
			COND_MATCH:    taken = rd_code == req_code_q;
			COND_EMPTY:    taken = cnt_q == '0;
			default:       taken = 1'b0;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else if (go) begin
			if (uw.cond == COND_DISPATCH) begin
				pc_q <= dispatch(req_type);
			end else if (taken) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + STEP_W'(1);
			end
		end
	end

	// Latch the request payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_code_q  <= req_code;
			req_value_q <= item_value;
		end
	end

	// Update index, count and total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			total_q <= '0;
		end else if (go) begin
			unique case (uw.idx_op)
				IDX_CLEAR: idx_q <= '0;
				IDX_INC:   idx_q <= idx_q + CNT_W'(1);
				default:   idx_q <= idx_q;
			endcase
			unique case (uw.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			unique case (uw.tot_op)
				TOT_ADD: total_q <= total_q + TOTAL_W'(req_value_q);
				TOT_SUB: total_q <= total_q - TOTAL_W'(rd_value);
				default: total_q <= total_q;
			endcase
		end
	end

	// Drive the entry RAM ports
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data;
		unique case (uw.wr_op)
			WR_APPEND: begin
				wr_en   = go;
				wr_addr = cnt_q[IDX_W-1:0];
				wr_data = {req_code_q, req_value_q};
			end
			WR_SHIFT: begin
				wr_en   = go;
				wr_addr = idx_q[IDX_W-1:0];
				wr_data = rd_data;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_addr = uw.rd_next ? IDX_W'(idx_q + CNT_W'(1)) : idx_q[IDX_W-1:0];

	ckt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Hold or drop the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_status_q <= uw.status;
			out_count_q  <= ECNT_W'(cnt_q);
			out_total_q  <= total_q;
			if (uw.status == ST_ENTRY) begin
				out_code_q  <= rd_code;
				out_value_q <= rd_value;
				out_last_q  <= idx_last;
			end else begin
				out_code_q  <= '0;
				out_value_q <= '0;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign value_total = out_total_q;
	assign entry_code  = out_code_q;
	assign entry_value = out_value_q;
	assign last        = out_last_q;

	// Check table bookkeeping
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("held count exceeds table depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q)
		else $error("entry index runs past held count");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> ($past(pc_q) == STEP_APP_WR || $past(pc_q) == STEP_SH_END))
		else $error("held count changed outside append or compaction end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a stalled result");

	a_wr_steps: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (pc_q == STEP_APP_WR || pc_q == STEP_SH_WR))
		else $error("entry RAM written outside a write step");

endmodule

// File: tb/compacting_keyed_table_tb.sv
// ----------------------------------------------------------------------------
// compacting_keyed_table_tb: self-checking bench for the compacting keyed table
// Drives append, delete, list and unknown requests through the valid/stall
// ports, predicts each result from a shadow copy of the table, and checks
// every result field by field in order. Sender and receiver idle at random,
// and one phase holds off the result side long enough to back up the input.
// ----------------------------------------------------------------------------
module compacting_keyed_table_tb;
	import ckt_pkg::*;

	// Request code that the block treats as a no-op
	localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int HOLD_OFF_LEN   = 400;

	typedef struct {
		status_t            status;
		logic [ECNT_W-1:0]  count;
		logic [TOTAL_W-1:0] total;
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic               last;
	} table_result_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [REQ_W-1:0]   req_type   = '0;
	logic [CODE_W-1:0]  req_code   = '0;
	logic [VALUE_W-1:0] item_value = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [ECNT_W-1:0]  entry_count;
	logic [TOTAL_W-1:0] value_total;
	logic [CODE_W-1:0]  entry_code;
	logic [VALUE_W-1:0] entry_value;
	logic               last;

	// Shadow table and pending results
	logic [CODE_W-1:0]  table_codes[$];
	logic [VALUE_W-1:0] table_values[$];
	logic [TOTAL_W-1:0] table_total = '0;
	table_result_t      expected_results[$];

	int mismatch_count  = 0;
	int hold_off_cycles = 0;
	int recv_stall_max  = 0;
	bit sender_idles    = 1'b0;
	int burst_left      = 0;

	compacting_keyed_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.req_code    (req_code),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_count (entry_count),
		.value_total (value_total),
		.entry_code  (entry_code),
		.entry_value (entry_value),
		.last        (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	function automatic void push_result(input status_t st, input logic [CODE_W-1:0] code,
			input logic [VALUE_W-1:0] value, input logic fin);
		table_result_t r;
		r.status = st;
		r.count  = ECNT_W'(table_codes.size());
		r.total  = table_total;
		r.code   = code;
		r.value  = value;
		r.last   = fin;
		expected_results.push_back(r);
	endfunction

	// Apply one request to the shadow table and queue what it answers
	function automatic void predict_request(input logic [REQ_W-1:0] req,
			input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value);
		int hit;
		hit = -1;
		case (req)
			REQ_APPEND: begin
				if (table_codes.size() >= DEPTH) begin
					push_result(ST_FULL, '0, '0, 1'b1);
				end else begin
					table_codes.push_back(code);
					table_values.push_back(value);
					table_total = table_total + TOTAL_W'(value);
					push_result(ST_DONE, '0, '0, 1'b1);
				end
			end
			REQ_DELETE: begin
				foreach (table_codes[i])
					if (hit < 0 && table_codes[i] == code)
						hit = i;
				if (hit < 0) begin
					push_result(ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					table_total = table_total - TOTAL_W'(table_values[hit]);
					table_codes.delete(hit);
					table_values.delete(hit);
					push_result(ST_DONE, '0, '0, 1'b1);
				end
			end
			REQ_LIST: begin
				if (table_codes.size() == 0)
					push_result(ST_EMPTY, '0, '0, 1'b1);
				else
					foreach (table_codes[i])
						push_result(ST_ENTRY, table_codes[i], table_values[i],
							i == table_codes.size() - 1);
			end
			default: begin
				push_result(ST_DONE, '0, '0, 1'b1);
			end
		endcase
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [CODE_W-1:0] code,
			input logic [VALUE_W-1:0] value);
		req_type   <= req;
		req_code   <= code;
		item_value <= value;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_request(req, code, value);
		pace_sender();
	endtask

	// Insert a gap between bursts when the sender is allowed to idle
	task automatic pace_sender();
		int gap;
		if (!sender_idles)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left = $urandom_range(0, 12);
	endtask

	function automatic logic [CODE_W-1:0] random_code();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return VALUE_W'($urandom_range(0, 24'hFFFFFF));
		endcase
	endfunction

	// Pick a held code most of the time, a likely miss otherwise
	function automatic logic [CODE_W-1:0] delete_code();
		if (table_codes.size() > 0 && $urandom_range(0, 99) < 80)
			return table_codes[$urandom_range(0, table_codes.size() - 1)];
		return random_code();
	endfunction

	// Stop offering requests, then wait for every pending result
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Extremes, duplicate codes, misses, empty list and the no-op request
	task automatic test_directed();
		sender_idles   = 1'b1;
		recv_stall_max = 3;
		send_request(REQ_LIST, '0, '0);
		send_request(REQ_DELETE, '0, '0);
		send_request(REQ_NOP, '0, '0);
		send_request(REQ_APPEND, '0, '0);
		send_request(REQ_APPEND, '1, '1);
		send_request(REQ_APPEND, 32'hA5A5_A5A5, 24'h5A_5A5A);
		send_request(REQ_APPEND, 32'h5A5A_5A5A, 24'hA5_A5A5);
		send_request(REQ_APPEND, '0, 24'h12_3456);
		send_request(REQ_LIST, '1, '1);
		send_request(REQ_DELETE, '0, '1);
		send_request(REQ_LIST, '0, '0);
		send_request(REQ_DELETE, 32'h1234_5678, '0);
		send_request(REQ_DELETE, 32'h5A5A_5A5A, '0);
		send_request(REQ_DELETE, '0, '0);
		send_request(REQ_NOP, '1, '1);
		send_request(REQ_LIST, '0, '0);
		send_request(REQ_DELETE, '1, '0);
		send_request(REQ_DELETE, 32'hA5A5_A5A5, '0);
		send_request(REQ_LIST, '0, '0);
		send_request(REQ_DELETE, 32'hA5A5_A5A5, '0);
	endtask

	// Fill to the limit, overflow it, list it all, then drain it in random order
	task automatic test_full_table();
		sender_idles   = 1'b1;
		recv_stall_max = 6;
		while (table_codes.size() < DEPTH)
			send_request(REQ_APPEND, random_code(), random_value());
		send_request(REQ_APPEND, random_code(), random_value());
		send_request(REQ_APPEND, '1, '1);
		send_request(REQ_LIST, '0, '0);
		send_request(REQ_DELETE, table_codes[DEPTH - 1], '0);
		send_request(REQ_APPEND, random_code(), random_value());
		send_request(REQ_DELETE, table_codes[0], '0);
		while (table_codes.size() > 0)
			send_request(REQ_DELETE, delete_code(), '0);
		send_request(REQ_LIST, '0, '0);
	endtask

	// Hold off the result side while requests keep coming, to back up the input
	task automatic test_result_backpressure();
		sender_idles    = 1'b0;
		recv_stall_max  = 0;
		hold_off_cycles = HOLD_OFF_LEN;
		repeat (12)
			send_request(REQ_APPEND, random_code(), random_value());
		send_request(REQ_LIST, '0, '0);
		send_request(REQ_DELETE, delete_code(), '0);
		send_request(REQ_NOP, random_code(), random_value());
		send_request(REQ_LIST, '0, '0);
		wait_results_drained();
	endtask

	// Mixed traffic steered toward a moving fill level
	task automatic test_random_traffic(input int count);
		int fill_goal;
		int pick;
		logic [CODE_W-1:0] code;
		fill_goal = 0;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				fill_goal      = $urandom_range(0, DEPTH + 2);
				sender_idles   = $urandom_range(0, 3) != 0;
				recv_stall_max = $urandom_range(0, 8);
			end
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_request(REQ_NOP, random_code(), random_value());
			end else if (pick < 10) begin
				send_request(REQ_LIST, random_code(), random_value());
			end else if ((table_codes.size() < fill_goal) == (pick < 78)) begin
				// reuse a held code now and then to build duplicates
				if (table_codes.size() > 0 && $urandom_range(0, 3) == 0)
					code = table_codes[$urandom_range(0, table_codes.size() - 1)];
				else
					code = random_code();
				send_request(REQ_APPEND, code, random_value());
			end else begin
				send_request(REQ_DELETE, delete_code(), random_value());
			end
		end
	endtask

	// Result side: stall in runs of random length unless held off or stalls are disabled
	initial begin : result_side
		int hold_left;
		int run_left;
		bit stalled;
		hold_left = 0;
		run_left  = 0;
		stalled   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_left       = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_stall_max == 0) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stalled  = !stalled;
					run_left = stalled ? $urandom_range(1, recv_stall_max) : $urandom_range(1, 8);
				end
				run_left--;
				out_stall <= stalled;
			end
		end
	end

	// Compare each result with the oldest pending one
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(status), '0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (entry_count !== want.count)
					report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
				if (value_total !== want.total)
					report_mismatch("value_total", 32'(value_total), 32'(want.total));
				if (entry_code !== want.code)
					report_mismatch("entry_code", entry_code, want.code);
				if (entry_value !== want.value)
					report_mismatch("entry_value", 32'(entry_value), 32'(want.value));
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	// End the run when neither side moves for too long
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_result_backpressure();
		test_random_traffic(180);
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
